/* rtl/core/ptscs_pkg.sv */
package ptscs_pkg;

  // Field widths of one transaction on either channel.
  localparam int unsigned KindW   = 2;
  localparam int unsigned TidW    = 32;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned StatusW = 4;
  localparam int unsigned SlotOW  = 8;
  localparam int unsigned DepthOW = 7;

  typedef enum logic [KindW-1:0] {
    KIND_ENTER = 2'd0,
    KIND_EXIT  = 2'd1,
    KIND_DUMP  = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_PUSHED     = 4'd0,
    ST_NEW_THREAD = 4'd1,
    ST_STACK_FULL = 4'd2,
    ST_TABLE_FULL = 4'd3,
    ST_POPPED     = 4'd4,
    ST_MISMATCH   = 4'd5,
    ST_UNKNOWN    = 4'd6,
    ST_FRAME      = 4'd7,
    ST_DUMP_EMPTY = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEPTH,
    S_TOP,
    S_DUMP_D,
    S_DUMP,
    S_EMIT
  } state_e;

endpackage

/* rtl/core/ptscs_ram.sv */
module ptscs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/per_thread_shadow_call_stack.sv */
// Per-thread shadow call stack.
// Input channel (in_valid_i / in_ready_o) carries one transaction per call
// event: kind_i selects enter, exit or dump; tid_i names the thread and
// fn_addr_i the function. Output channel (out_valid_o / out_ready_i) returns
// one result per enter or exit, and one frame per stack entry for a dump
// (top first, last_o on the bottom frame), or a single dump-empty result.
// Items are worked one at a time. An enter or exit whose thread matches the
// last looked-up thread reads its depth (S_DEPTH), an exit then its top frame
// (S_TOP), and the result is loaded in S_EMIT; otherwise the thread table
// memory is first scanned one slot per cycle over the used slots. The scan of
// the id table is what sets the rate. A dump streams one frame per cycle while
// the receiver takes them. Kind 3 is taken and dropped without a result.
// A one-entry output register holds the result; while the receiver stalls
// the block finishes its current item and waits, and accepts the next item
// once it is back in idle. Reset clears the slot count, the recent slot and
// the lookup cache; the memories are not cleared, since no entry is read
// before it is written.
module per_thread_shadow_call_stack #(
  parameter int unsigned THREAD_SLOTS = 256,
  parameter int unsigned STACK_LIMIT  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ptscs_pkg::KindW-1:0]    kind_i,
  input  logic [ptscs_pkg::TidW-1:0]     tid_i,
  input  logic [ptscs_pkg::AddrW-1:0]    fn_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ptscs_pkg::StatusW-1:0]  status_o,
  output logic [ptscs_pkg::SlotOW-1:0]   slot_o,
  output logic [ptscs_pkg::DepthOW-1:0]  depth_o,
  output logic [ptscs_pkg::AddrW-1:0]    frame_addr_o,
  output logic                           last_o
);

  import ptscs_pkg::*;

  localparam int unsigned SlotW   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned UsedW   = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned DepW    = $clog2(STACK_LIMIT + 1);
  localparam int unsigned Frames  = THREAD_SLOTS * STACK_LIMIT;
  localparam int unsigned FrameAW = (Frames > 1) ? $clog2(Frames) : 1;

  // Flat frame index: slot * STACK_LIMIT + position.
  function automatic logic [FrameAW-1:0] frame_idx(logic [SlotW-1:0] s,
                                                   logic [DepW-1:0] d);
    int unsigned tmp;
    tmp = int'(s) * STACK_LIMIT + int'(d);
    return FrameAW'(tmp);
  endfunction

  // Control state
  state_e              state_q, state_d;
  logic [UsedW-1:0]    used_q, used_d;
  logic [SlotW-1:0]    recent_q, recent_d;
  logic                hit_valid_q, hit_valid_d;
  logic                out_valid_q, out_valid_d;

  // Payload state
  kind_e               kind_q, kind_d;
  logic [TidW-1:0]     tid_q, tid_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [DepW-1:0]     dep_q, dep_d;
  logic [SlotW-1:0]    idx_q, idx_d;
  logic [TidW-1:0]     hit_tid_q, hit_tid_d;
  logic [SlotW-1:0]    hit_slot_q, hit_slot_d;
  status_e             pend_status_q, pend_status_d;
  logic [SlotW-1:0]    pend_slot_q, pend_slot_d;
  logic [DepW-1:0]     pend_depth_q, pend_depth_d;
  status_e             out_status_q, out_status_d;
  logic [SlotW-1:0]    out_slot_q, out_slot_d;
  logic [DepW-1:0]     out_depth_q, out_depth_d;
  logic [AddrW-1:0]    out_frame_q, out_frame_d;
  logic                out_last_q, out_last_d;

  // Memory ports
  logic                thr_we, thr_re;
  logic [SlotW-1:0]    thr_waddr, thr_raddr;
  logic [TidW-1:0]     thr_wdata, thr_rdata;
  logic                dep_we, dep_re;
  logic [SlotW-1:0]    dep_waddr, dep_raddr;
  logic [DepW-1:0]     dep_wdata, dep_rdata;
  logic                frm_we, frm_re;
  logic [FrameAW-1:0]  frm_waddr, frm_raddr;
  logic [AddrW-1:0]    frm_wdata, frm_rdata;

  logic                out_free;
  logic [SlotW+SlotOW-1:0] slot_ext;

  ptscs_ram #(.WIDTH(TidW), .DEPTH(THREAD_SLOTS)) u_thread_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .re_i    (thr_re),
    .raddr_i (thr_raddr),
    .rdata_o (thr_rdata)
  );

  ptscs_ram #(.WIDTH(DepW), .DEPTH(THREAD_SLOTS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  ptscs_ram #(.WIDTH(AddrW), .DEPTH(Frames)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .re_i    (frm_re),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    recent_d      = recent_q;
    hit_valid_d   = hit_valid_q;
    kind_d        = kind_q;
    tid_d         = tid_q;
    addr_d        = addr_q;
    slot_d        = slot_q;
    dep_d         = dep_q;
    idx_d         = idx_q;
    hit_tid_d     = hit_tid_q;
    hit_slot_d    = hit_slot_q;
    pend_status_d = pend_status_q;
    pend_slot_d   = pend_slot_q;
    pend_depth_d  = pend_depth_q;
    out_status_d  = out_status_q;
    out_slot_d    = out_slot_q;
    out_depth_d   = out_depth_q;
    out_frame_d   = out_frame_q;
    out_last_d    = out_last_q;

    thr_we = 1'b0; thr_waddr = '0; thr_wdata = tid_q;
    thr_re = 1'b0; thr_raddr = '0;
    dep_we = 1'b0; dep_waddr = slot_q; dep_wdata = '0;
    dep_re = 1'b0; dep_raddr = '0;
    frm_we = 1'b0; frm_waddr = '0; frm_wdata = addr_q;
    frm_re = 1'b0; frm_raddr = '0;

    // Drop the held result once the receiver takes it.
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_e'(kind_i);
          tid_d  = tid_i;
          addr_d = fn_addr_i;
          unique case (kind_e'(kind_i))
            KIND_ENTER, KIND_EXIT: begin
              if (hit_valid_q && (hit_tid_q == tid_i)) begin
                slot_d    = hit_slot_q;
                dep_re    = 1'b1;
                dep_raddr = hit_slot_q;
                state_d   = S_DEPTH;
              end else begin
                idx_d     = '0;
                thr_re    = 1'b1;
                thr_raddr = '0;
                state_d   = S_SCAN;
              end
            end
            KIND_DUMP: begin
              if (used_q == '0) begin
                pend_status_d = ST_DUMP_EMPTY;
                pend_slot_d   = recent_q;
                pend_depth_d  = '0;
                state_d       = S_EMIT;
              end else begin
                dep_re    = 1'b1;
                dep_raddr = recent_q;
                state_d   = S_DUMP_D;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if ((int'(idx_q) < int'(used_q)) && (thr_rdata == tid_q)) begin
          slot_d      = idx_q;
          hit_valid_d = 1'b1;
          hit_tid_d   = tid_q;
          hit_slot_d  = idx_q;
          dep_re      = 1'b1;
          dep_raddr   = idx_q;
          state_d     = S_DEPTH;
        end else if (int'(idx_q) + 1 < int'(used_q)) begin
          idx_d     = idx_q + SlotW'(1);
          thr_re    = 1'b1;
          thr_raddr = idx_q + SlotW'(1);
        end else begin
          state_d = S_EMIT;
          if (kind_q == KIND_EXIT) begin
            pend_status_d = ST_UNKNOWN;
            pend_slot_d   = '0;
            pend_depth_d  = '0;
          end else if (used_q == UsedW'(THREAD_SLOTS)) begin
            pend_status_d = ST_TABLE_FULL;
            pend_slot_d   = '0;
            pend_depth_d  = '0;
          end else begin
            // Allocate the next free slot and push the first frame.
            thr_we        = 1'b1;
            thr_waddr     = used_q[SlotW-1:0];
            dep_we        = 1'b1;
            dep_waddr     = used_q[SlotW-1:0];
            dep_wdata     = DepW'(1);
            frm_we        = 1'b1;
            frm_waddr     = frame_idx(used_q[SlotW-1:0], '0);
            used_d        = used_q + UsedW'(1);
            recent_d      = used_q[SlotW-1:0];
            hit_valid_d   = 1'b1;
            hit_tid_d     = tid_q;
            hit_slot_d    = used_q[SlotW-1:0];
            pend_status_d = ST_NEW_THREAD;
            pend_slot_d   = used_q[SlotW-1:0];
            pend_depth_d  = DepW'(1);
          end
        end
      end

      S_DEPTH: begin
        pend_slot_d = slot_q;
        state_d     = S_EMIT;
        if (kind_q == KIND_ENTER) begin
          if (int'(dep_rdata) >= STACK_LIMIT) begin
            pend_status_d = ST_STACK_FULL;
            pend_depth_d  = dep_rdata;
          end else begin
            frm_we        = 1'b1;
            frm_waddr     = frame_idx(slot_q, dep_rdata);
            dep_we        = 1'b1;
            dep_wdata     = dep_rdata + DepW'(1);
            recent_d      = slot_q;
            pend_status_d = ST_PUSHED;
            pend_depth_d  = dep_rdata + DepW'(1);
          end
        end else if (dep_rdata == '0) begin
          pend_status_d = ST_MISMATCH;
          pend_depth_d  = '0;
        end else begin
          // Fetch the top frame for the address compare.
          dep_d     = dep_rdata - DepW'(1);
          frm_re    = 1'b1;
          frm_raddr = frame_idx(slot_q, dep_rdata - DepW'(1));
          state_d   = S_TOP;
        end
      end

      S_TOP: begin
        pend_slot_d = slot_q;
        state_d     = S_EMIT;
        if (frm_rdata == addr_q) begin
          dep_we        = 1'b1;
          dep_wdata     = dep_q;
          pend_status_d = ST_POPPED;
          pend_depth_d  = dep_q;
        end else begin
          pend_status_d = ST_MISMATCH;
          pend_depth_d  = dep_q + DepW'(1);
        end
      end

      S_DUMP_D: begin
        if (dep_rdata == '0) begin
          pend_status_d = ST_DUMP_EMPTY;
          pend_slot_d   = recent_q;
          pend_depth_d  = '0;
          state_d       = S_EMIT;
        end else begin
          dep_d     = dep_rdata - DepW'(1);
          frm_re    = 1'b1;
          frm_raddr = frame_idx(recent_q, dep_rdata - DepW'(1));
          state_d   = S_DUMP;
        end
      end

      S_DUMP: begin
        // Frame data holds in the memory output until the result is loaded.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_FRAME;
          out_slot_d   = recent_q;
          out_depth_d  = dep_q;
          out_frame_d  = frm_rdata;
          out_last_d   = (dep_q == '0);
          if (dep_q == '0) begin
            state_d = S_IDLE;
          end else begin
            dep_d     = dep_q - DepW'(1);
            frm_re    = 1'b1;
            frm_raddr = frame_idx(recent_q, dep_q - DepW'(1));
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_slot_d   = pend_slot_q;
          out_depth_d  = pend_depth_q;
          out_frame_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      recent_q    <= '0;
      hit_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      recent_q    <= recent_d;
      hit_valid_q <= hit_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    tid_q         <= tid_d;
    addr_q        <= addr_d;
    slot_q        <= slot_d;
    dep_q         <= dep_d;
    idx_q         <= idx_d;
    hit_tid_q     <= hit_tid_d;
    hit_slot_q    <= hit_slot_d;
    pend_status_q <= pend_status_d;
    pend_slot_q   <= pend_slot_d;
    pend_depth_q  <= pend_depth_d;
    out_status_q  <= out_status_d;
    out_slot_q    <= out_slot_d;
    out_depth_q   <= out_depth_d;
    out_frame_q   <= out_frame_d;
    out_last_q    <= out_last_d;
  end

  // Report the low bits of the slot, zero-extended when the table is small.
  assign slot_ext     = {{SlotOW{1'b0}}, out_slot_q};
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = slot_ext[SlotOW-1:0];
  assign depth_o      = DepthOW'(out_depth_q);
  assign frame_addr_o = out_frame_q;
  assign last_o       = out_last_q;

endmodule

/* tb/sv/ptscs_result_check.sv */
`timescale 1ns / 1ps

module ptscs_result_check #(
  parameter int unsigned THREAD_SLOTS = 256,
  parameter int unsigned STACK_LIMIT  = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [ptscs_pkg::KindW-1:0]   kind_i,
  input  logic [ptscs_pkg::TidW-1:0]    tid_i,
  input  logic [ptscs_pkg::AddrW-1:0]   fn_addr_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ptscs_pkg::StatusW-1:0] status_i,
  input  logic [ptscs_pkg::SlotOW-1:0]  slot_i,
  input  logic [ptscs_pkg::DepthOW-1:0] depth_i,
  input  logic [ptscs_pkg::AddrW-1:0]   frame_addr_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            items_o,
  output int                            results_o,
  output int                            stack_full_o,
  output int                            table_full_o,
  output int                            longest_dump_o
);

  import ptscs_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SlotOW-1:0]  slot;
    logic [DepthOW-1:0] depth;
    logic [AddrW-1:0]   frame_addr;
    logic               last;
  } call_result_t;

  // Own copy of the thread table and the stacks.
  logic [TidW-1:0]  tid_of_slot   [THREAD_SLOTS];
  int unsigned      depth_of_slot [THREAD_SLOTS];
  logic [AddrW-1:0] frame_mem     [THREAD_SLOTS][STACK_LIMIT];
  int unsigned      slots_taken;
  int unsigned      recent;

  call_result_t expected_results[$];
  call_result_t want;

  function automatic void add_expected(input status_e st, input int unsigned s,
                                       input int unsigned d, input logic [AddrW-1:0] a,
                                       input logic lst);
    call_result_t r;
    r.status     = st;
    r.slot       = s[SlotOW-1:0];
    r.depth      = d[DepthOW-1:0];
    r.frame_addr = a;
    r.last       = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_call_event(input logic [KindW-1:0] kind,
                                             input logic [TidW-1:0] tid,
                                             input logic [AddrW-1:0] addr);
    int          s;
    int unsigned d;
    s = -1;
    for (int i = 0; i < slots_taken; i++) begin
      if (s < 0 && tid_of_slot[i] == tid) s = i;
    end
    case (kind)
      KIND_ENTER: begin
        if (s >= 0) begin
          d = depth_of_slot[s];
          if (d >= STACK_LIMIT) begin
            add_expected(ST_STACK_FULL, s, d, '0, 1'b1);
            stack_full_o++;
          end else begin
            frame_mem[s][d] = addr;
            depth_of_slot[s] = d + 1;
            recent = s;
            add_expected(ST_PUSHED, s, d + 1, '0, 1'b1);
          end
        end else if (slots_taken >= THREAD_SLOTS) begin
          add_expected(ST_TABLE_FULL, 0, 0, '0, 1'b1);
          table_full_o++;
        end else begin
          s = slots_taken;
          tid_of_slot[s] = tid;
          frame_mem[s][0] = addr;
          depth_of_slot[s] = 1;
          slots_taken++;
          recent = s;
          add_expected(ST_NEW_THREAD, s, 1, '0, 1'b1);
        end
      end
      KIND_EXIT: begin
        if (s < 0) begin
          add_expected(ST_UNKNOWN, 0, 0, '0, 1'b1);
        end else begin
          d = depth_of_slot[s];
          if (d > 0 && frame_mem[s][d-1] == addr) begin
            depth_of_slot[s] = d - 1;
            add_expected(ST_POPPED, s, d - 1, '0, 1'b1);
          end else begin
            add_expected(ST_MISMATCH, s, d, '0, 1'b1);
          end
        end
      end
      KIND_DUMP: begin
        if (slots_taken == 0 || depth_of_slot[recent] == 0) begin
          add_expected(ST_DUMP_EMPTY, recent, 0, '0, 1'b1);
        end else begin
          d = depth_of_slot[recent];
          if (d > longest_dump_o) longest_dump_o = d;
          while (d > 0) begin
            d--;
            add_expected(ST_FRAME, recent, d, frame_mem[recent][d], d == 0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_taken = 0;
      recent = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      items_o = 0;
      results_o = 0;
      stack_full_o = 0;
      table_full_o = 0;
      longest_dump_o = 0;
    end else begin
      // A result never shares an edge with its own input, so predict first.
      if (in_valid_i && in_ready_i) begin
        if (kind_i <= KIND_DUMP) items_o++;
        predict_call_event(kind_i, tid_i, fn_addr_i);
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result %0d with nothing expected: status %0d slot %0d depth %0d",
                     results_o, status_i, slot_i, depth_i);
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status || slot_i !== want.slot ||
              depth_i !== want.depth || frame_addr_i !== want.frame_addr ||
              last_i !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("result %0d mismatch: expected status %0d slot %0d depth %0d",
                       results_o, want.status, want.slot, want.depth);
              $display("  expected addr %h last %0d", want.frame_addr, want.last);
              $display("  got status %0d slot %0d depth %0d addr %h last %0d",
                       status_i, slot_i, depth_i, frame_addr_i, last_i);
            end
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/per_thread_shadow_call_stack_test.sv */
`timescale 1ns / 1ps

module per_thread_shadow_call_stack_test;
  import ptscs_pkg::*;

  localparam int unsigned THREAD_SLOTS = 256;
  localparam int unsigned STACK_LIMIT  = 64;
  localparam int unsigned POOL         = 8;      // threads with tracked call chains
  localparam int unsigned PARK_CYCLES  = 400;    // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 600;    // covers a full table scan
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned FILL_COUNT   = 8;      // fresh threads to lengthen the scan
  localparam logic [TidW-1:0]  FILL_BASE  = 32'hF00D_0000;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KindW-1:0]   kind = KIND_ENTER;
  logic [TidW-1:0]    call_tid = '0;
  logic [AddrW-1:0]   call_addr = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StatusW-1:0] status;
  logic [SlotOW-1:0]  slot;
  logic [DepthOW-1:0] depth;
  logic [AddrW-1:0]   frame_addr;
  logic               last;

  int fail_count, pending, items, results, stack_full_hits, table_full_hits, longest_dump;

  // Idle rates in percent; written only right after a rising edge so that the
  // falling-edge drivers never race them.
  int gap_pct = 6;
  int stall_pct = 57;
  bit park_req = 1'b0;
  bit park_taken = 1'b0;
  int park_left = 0;
  int cycle_count = 0;

  // Stimulus-side view of the pooled threads' stacks, used only to shape
  // well-formed call/return sequences; checking is done by the checker.
  logic [TidW-1:0]  pool_tid    [POOL];
  logic [AddrW-1:0] pool_frames [POOL][STACK_LIMIT];
  int unsigned      pool_depth  [POOL];

  always #5 clk = ~clk;

  per_thread_shadow_call_stack #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .STACK_LIMIT (STACK_LIMIT)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .tid_i       (call_tid),
    .fn_addr_i   (call_addr),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .slot_o      (slot),
    .depth_o     (depth),
    .frame_addr_o(frame_addr),
    .last_o      (last)
  );

  ptscs_result_check #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .STACK_LIMIT (STACK_LIMIT)
  ) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .tid_i         (call_tid),
    .fn_addr_i     (call_addr),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .slot_i        (slot),
    .depth_i       (depth),
    .frame_addr_i  (frame_addr),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_o       (items),
    .results_o     (results),
    .stack_full_o  (stack_full_hits),
    .table_full_o  (table_full_hits),
    .longest_dump_o(longest_dump)
  );

  // Receiver: random stalls, plus one long hold-off on request. The hold-off
  // is counted here so it runs on its own while the sender keeps offering.
  always @(negedge clk) begin
    if (park_req && !park_taken) begin
      park_taken <= 1'b1;
      park_left <= PARK_CYCLES;
      out_ready <= 1'b0;
    end else if (park_left != 0) begin
      park_left <= park_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one transaction: idle at random first, then hold valid and payload
  // until the block takes it. Returns right after the accepting edge.
  task automatic offer(input logic [KindW-1:0] k, input logic [TidW-1:0] tid,
                       input logic [AddrW-1:0] a);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    call_tid <= tid;
    call_addr <= a;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Mostly fully random addresses, with the all-zero and all-one extremes.
  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Call into a pooled thread; track the frame unless its stack is full.
  task automatic enter_pool(input int i);
    logic [AddrW-1:0] a;
    a = pick_addr();
    offer(KIND_ENTER, pool_tid[i], a);
    if (pool_depth[i] < STACK_LIMIT) begin
      pool_frames[i][pool_depth[i]] = a;
      pool_depth[i]++;
    end
  endtask

  // Return from the top frame of a pooled thread with the matching address.
  task automatic exit_pool(input int i);
    offer(KIND_EXIT, pool_tid[i], pool_frames[i][pool_depth[i]-1]);
    pool_depth[i]--;
  endtask

  // One random step: mostly well-formed calls and returns on pooled threads,
  // the rest dumps, bad returns, unknown threads, fresh threads and unused kind.
  task automatic random_step();
    int i;
    int roll;
    i = $urandom_range(POOL-1);
    roll = $urandom_range(99);
    if (roll < 45 || (roll < 75 && pool_depth[i] == 0)) enter_pool(i);
    else if (roll < 75) exit_pool(i);
    else if (roll < 83) offer(KIND_DUMP, $urandom, pick_addr());
    else if (roll < 88) offer(KIND_EXIT, pool_tid[i], pick_addr());
    else if (roll < 93) offer(KIND_EXIT, $urandom, pick_addr());
    else if (roll < 96) offer(KIND_UNUSED, $urandom, pick_addr());
    else offer(KIND_ENTER, $urandom, pick_addr());
  endtask

  initial begin
    int deep;
    for (int i = 0; i < POOL; i++) begin
      pool_tid[i] = ($urandom & 32'hFFFF_FFF0) | i;
      pool_depth[i] = 0;
    end

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: dump and exit with an empty table, push/pop/mismatch on one
    // thread, exit on an empty stack, dump of an emptied recent thread,
    // unused kind, extreme ids and addresses, and exit leaving recent alone.
    offer(KIND_DUMP, '0, '0);
    offer(KIND_EXIT, '0, '1);
    offer(KIND_ENTER, '1, '1);
    offer(KIND_ENTER, '1, '0);
    offer(KIND_DUMP, '0, '0);
    offer(KIND_EXIT, '1, 64'd1);
    offer(KIND_EXIT, '1, '0);
    offer(KIND_EXIT, '1, '1);
    offer(KIND_EXIT, '1, '1);
    offer(KIND_DUMP, '1, '1);
    offer(KIND_UNUSED, '1, '1);
    offer(KIND_ENTER, '0, 64'h5555_5555_5555_5555);
    offer(KIND_ENTER, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    offer(KIND_EXIT, '1, '0);
    offer(KIND_ENTER, 32'h5555_5555, 64'h8000_0000_0000_0001);
    offer(KIND_EXIT, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    offer(KIND_DUMP, '0, '0);
    offer(KIND_ENTER, '1, 64'h0123_4567_89AB_CDEF);
    offer(KIND_DUMP, 32'h5555_5555, '0);
    offer(KIND_EXIT, 32'hAAAA_AAAA, '0);

    // Allocate every pooled thread while the table has room.
    for (int i = 0; i < POOL; i++) enter_pool(i);

    // Phase one: sender rarely idles, receiver stalls often.
    repeat (30) random_step();

    // Phase two: the other way round.
    gap_pct = 57;
    stall_pct = 6;
    repeat (30) random_step();

    // Phase three: no idling on either side.
    gap_pct = 0;
    stall_pct = 0;

    // Deep call chain: fill one stack, push past the limit, then dump the
    // whole stack while the receiver is parked so the block backs up.
    deep = $urandom_range(POOL-1);
    while (pool_depth[deep] < STACK_LIMIT) enter_pool(deep);
    enter_pool(deep);
    enter_pool(deep);
    park_req = 1'b1;
    offer(KIND_DUMP, '0, '0);
    repeat (10) random_step();
    repeat (20) if (pool_depth[deep] != 0) exit_pool(deep);
    repeat (10) random_step();

    // A batch of fresh threads, then an unknown exit and a dump.
    for (int k = 0; k < FILL_COUNT; k++) offer(KIND_ENTER, FILL_BASE + k, pick_addr());
    offer(KIND_EXIT, FILL_BASE - 1, '0);
    offer(KIND_DUMP, '0, '0);
    repeat (10) random_step();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then let the block sit long enough to expose any stray result.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d call events and %0d results; %0d stack-full, %0d table-full",
             items, results, stack_full_hits, table_full_hits);
    $display("longest dump %0d frames, with a %0d-cycle receiver hold-off",
             longest_dump, PARK_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule
